// ----- design/ohash_pkg.sv -----
// ohash_pkg: types and codes shared by the open-addressing hash table modules.
// Depends on nothing; ohash_front, ohash_back and the top level use it by scoped names.
package ohash_pkg;

    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int COUNT_BITS = 7;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_LOOKUP = 2'd2;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_PROBE_LIM = 2'd2;
    localparam logic [1:0] STAT_FULL      = 2'd3;

    localparam logic [1:0] SLOT_NEVER   = 2'd0;
    localparam logic [1:0] SLOT_FILLED  = 2'd1;
    localparam logic [1:0] SLOT_REMOVED = 2'd2;

    typedef struct packed {
        logic [1:0]                  mode;
        logic signed [KEY_BITS-1:0]  key;
        logic [VALUE_BITS-1:0]       value;
    } t_in;

    typedef struct packed {
        logic [1:0]            status;
        logic [VALUE_BITS-1:0] found_value;
        logic [COUNT_BITS-1:0] entry_count;
    } t_out;

    typedef struct packed {
        logic [1:0]            state;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } t_row;

    typedef struct packed {
        logic clearing;
        logic idle;
    } t_back_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_CHECK
    } t_back_state;

endpackage

// ----- design/ohash_ram.sv -----
// ohash_ram: generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module ohash_ram #(
    parameter int WIDTH = 66,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/ohash_fifo.sv -----
// ohash_fifo: small first-in first-out queue of registers.
// Depends on nothing; used on both sides of the probe engine.
module ohash_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_buf [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;
    logic             w_push, w_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wp] <= i_data;
        end
    end

endmodule

// ----- design/ohash_front.sv -----
// ohash_front: accepts request items, works out the home slot, queues them.
// Depends on ohash_pkg and ohash_fifo.
module ohash_front #(
    parameter int CAPACITY = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  ohash_pkg::t_in              i_item,
    input  logic                        i_hold,
    output logic                        o_full,
    output logic                        o_cmd_valid,
    output ohash_pkg::t_in              o_cmd_item,
    output logic [$clog2(CAPACITY)-1:0] o_cmd_home,
    input  logic                        i_cmd_pop
);

    localparam int AW = $clog2(CAPACITY);
    localparam int QW = $bits(ohash_pkg::t_in) + AW;

    logic [AW-1:0] w_k, w_home;
    logic [QW-1:0] w_qdata;
    logic          w_qfull, w_qempty;

    // home slot: 3*key, kept to the low address bits
    assign w_k    = i_item.key[AW-1:0];
    assign w_home = (w_k << 1) + w_k;

    ohash_fifo #(.WIDTH(QW), .DEPTH(2)) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push && !o_full),
        .i_data  ({w_home, i_item}),
        .o_full  (w_qfull),
        .i_pop   (i_cmd_pop),
        .o_data  (w_qdata),
        .o_empty (w_qempty)
    );

    assign o_full      = w_qfull || i_hold;
    assign o_cmd_valid = !w_qempty;
    assign o_cmd_item  = ohash_pkg::t_in'(w_qdata[$bits(ohash_pkg::t_in)-1:0]);
    assign o_cmd_home  = w_qdata[QW-1:$bits(ohash_pkg::t_in)];

endmodule

// ----- design/ohash_back.sv -----
// ohash_back: probe engine over the slot RAM, plus the result queue.
// Depends on ohash_pkg, ohash_ram and ohash_fifo.
module ohash_back #(
    parameter int CAPACITY = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [ohash_pkg::COUNT_BITS-1:0]    i_fill_limit,
    input  logic                                i_cmd_valid,
    input  ohash_pkg::t_in                      i_cmd_item,
    input  logic [$clog2(CAPACITY)-1:0]         i_cmd_home,
    output logic                                o_cmd_pop,
    output ohash_pkg::t_back_status             o_status,
    output ohash_pkg::t_out                     o_result,
    output logic                                o_empty,
    input  logic                                i_pop
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > ohash_pkg::COUNT_BITS) ? CW : ohash_pkg::COUNT_BITS;
    localparam int RW   = $bits(ohash_pkg::t_row);

    ohash_pkg::t_back_state r_state, n_state;
    logic [AW-1:0]  r_clr, n_clr;
    logic [1:0]     r_mode, n_mode;
    logic [ohash_pkg::KEY_BITS-1:0]   r_key, n_key;
    logic [ohash_pkg::VALUE_BITS-1:0] r_val, n_val;
    logic [AW-1:0]  r_p, n_p;
    logic [CW-1:0]  r_steps, n_steps;
    logic [CW-1:0]  r_count, n_count;

    logic           w_we, w_re;
    logic [AW-1:0]  w_waddr;
    ohash_pkg::t_row w_wrow, w_rrow;
    logic [RW-1:0]  w_rdata;
    logic           w_rpush, w_rfull;
    ohash_pkg::t_out w_res;
    logic           w_filled, w_match;
    logic [CW-1:0]  w_next_steps;
    logic [AW-1:0]  w_next_p;

    assign w_rrow       = ohash_pkg::t_row'(w_rdata);
    assign w_filled     = (w_rrow.state == ohash_pkg::SLOT_FILLED);
    assign w_match      = w_filled && (w_rrow.key == r_key);
    assign w_next_steps = r_steps + 1'b1;
    assign w_next_p     = (r_p << 2) + (r_p << 1) + 1'b1;

    ohash_ram #(.WIDTH(RW), .DEPTH(CAPACITY)) u_slots (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wrow),
        .i_re    (w_re),
        .i_raddr (r_p),
        .o_rdata (w_rdata)
    );

    ohash_fifo #(.WIDTH($bits(ohash_pkg::t_out)), .DEPTH(2)) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_rpush),
        .i_data  (w_res),
        .o_full  (w_rfull),
        .i_pop   (i_pop),
        .o_data  (o_result),
        .o_empty (o_empty)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ohash_pkg::S_CLEAR;
            r_clr   <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode  <= n_mode;
        r_key   <= n_key;
        r_val   <= n_val;
        r_p     <= n_p;
        r_steps <= n_steps;
    end

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        n_mode  = r_mode;
        n_key   = r_key;
        n_val   = r_val;
        n_p     = r_p;
        n_steps = r_steps;
        n_count = r_count;
        w_we    = 1'b0;
        w_re    = 1'b0;
        w_waddr = r_p;
        w_wrow  = '{state: ohash_pkg::SLOT_NEVER, key: '1, value: '0};
        w_rpush = 1'b0;
        o_cmd_pop = 1'b0;
        w_res.status      = ohash_pkg::STAT_OK;
        w_res.found_value = '0;
        case (r_state)
            ohash_pkg::S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                n_clr   = r_clr + 1'b1;
                if (r_clr == AW'(CAPACITY - 1)) begin
                    n_state = ohash_pkg::S_IDLE;
                end
            end
            ohash_pkg::S_IDLE: begin
                if (i_cmd_valid && !w_rfull) begin
                    o_cmd_pop = 1'b1;
                    n_mode  = i_cmd_item.mode;
                    n_key   = i_cmd_item.key;
                    n_val   = i_cmd_item.value;
                    n_p     = i_cmd_home;
                    n_steps = '0;
                    if (i_cmd_item.mode == ohash_pkg::MODE_INSERT &&
                        CMPW'(r_count) >= CMPW'(i_fill_limit)) begin
                        w_res.status = ohash_pkg::STAT_FULL;
                        w_rpush = 1'b1;
                    end else if (i_cmd_item.mode != ohash_pkg::MODE_INSERT &&
                                 i_cmd_item.mode != ohash_pkg::MODE_REMOVE &&
                                 i_cmd_item.mode != ohash_pkg::MODE_LOOKUP) begin
                        w_rpush = 1'b1;
                    end else begin
                        n_state = ohash_pkg::S_READ;
                    end
                end
            end
            ohash_pkg::S_READ: begin
                w_re    = 1'b1;
                n_state = ohash_pkg::S_CHECK;
            end
            ohash_pkg::S_CHECK: begin
                n_state = ohash_pkg::S_IDLE;
                case (r_mode)
                    ohash_pkg::MODE_INSERT: begin
                        if (r_steps == '0 && w_match) begin
                            // overwrite at home: count unchanged
                            w_we    = 1'b1;
                            w_wrow  = '{state: ohash_pkg::SLOT_FILLED, key: r_key, value: r_val};
                            w_rpush = 1'b1;
                        end else if (!w_filled) begin
                            w_we    = 1'b1;
                            w_wrow  = '{state: ohash_pkg::SLOT_FILLED, key: r_key, value: r_val};
                            n_count = r_count + 1'b1;
                            w_rpush = 1'b1;
                        end else if (r_steps == CW'(CAPACITY - 1)) begin
                            w_res.status = ohash_pkg::STAT_PROBE_LIM;
                            w_rpush = 1'b1;
                        end else begin
                            n_steps = w_next_steps;
                            n_p     = w_next_p;
                            n_state = ohash_pkg::S_READ;
                        end
                    end
                    default: begin
                        // remove and lookup share the chain walk
                        if (w_match) begin
                            w_rpush = 1'b1;
                            if (r_mode == ohash_pkg::MODE_REMOVE) begin
                                w_we    = 1'b1;
                                w_wrow  = '{state: ohash_pkg::SLOT_REMOVED, key: '1,
                                            value: '0};
                                n_count = r_count - 1'b1;
                            end else begin
                                w_res.found_value = w_rrow.value;
                            end
                        end else if (w_rrow.state == ohash_pkg::SLOT_NEVER) begin
                            w_res.status = ohash_pkg::STAT_NOT_FOUND;
                            w_rpush = 1'b1;
                        end else if (w_next_steps >= r_count) begin
                            w_res.status = ohash_pkg::STAT_PROBE_LIM;
                            w_rpush = 1'b1;
                        end else begin
                            n_steps = w_next_steps;
                            n_p     = w_next_p;
                            n_state = ohash_pkg::S_READ;
                        end
                    end
                endcase
            end
            default: begin
                n_state = ohash_pkg::S_IDLE;
            end
        endcase
        w_res.entry_count = ohash_pkg::COUNT_BITS'(n_count);
    end

    assign o_status.clearing = (r_state == ohash_pkg::S_CLEAR);
    assign o_status.idle     = (r_state == ohash_pkg::S_IDLE);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ohash_pkg::S_CLEAR) |-> !w_rpush && !o_cmd_pop)
        else $error("item handled during clearing pass");

    a_check_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ohash_pkg::S_CHECK) |-> $past(r_state) == ohash_pkg::S_READ)
        else $error("check without a slot read");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ohash_pkg::S_CHECK) |=> $stable(r_count))
        else $error("count moved outside a slot check");

endmodule

// ----- design/open_addressing_hash_table_top.sv -----
// open_addressing_hash_table_top: top level of the open-addressing hash table.
// Depends on ohash_pkg, ohash_front and ohash_back.
//
// Use: requests enter through a queue-like port (push/full, payload i_item:
// mode, key, value). Results leave through a queue-like port (empty/pop,
// payload o_result: status, found_value, entry_count), one per request,
// in request order. The fill limit is written through i_cfg_we/i_cfg_wdata by
// the user only while the block is idle, which the block itself does not
// enforce; it resets to 51.
// The front queues requests with their home slot; the probe engine walks the
// chain one slot read at a time (read, then check and write) through a slot
// RAM with one read port and one write port. A request is answered at once
// when refused (full table or unused mode); otherwise the probe chain sets
// the rate, and the engine takes a new request only when done with the last.
// After reset the engine clears the slot RAM, one slot a cycle; full stays
// high until that pass ends.
// When the receiver stops popping, two results wait in the result queue and
// two requests in the front queue, then full rises; nothing is dropped.
module open_addressing_hash_table_top #(
    parameter int CAPACITY = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  ohash_pkg::t_in                    i_item,
    output logic                              empty,
    input  logic                              pop,
    output ohash_pkg::t_out                   o_result,
    input  logic                              i_cfg_we,
    input  logic [ohash_pkg::COUNT_BITS-1:0]  i_cfg_wdata
);

    localparam int AW = $clog2(CAPACITY);

    logic [ohash_pkg::COUNT_BITS-1:0] r_fill_limit;
    logic                    w_cmd_valid, w_cmd_pop;
    ohash_pkg::t_in          w_cmd_item;
    logic [AW-1:0]           w_cmd_home;
    ohash_pkg::t_back_status w_bstat;

    // hold the fill limit; reset value is 0.8 of the default capacity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_limit <= 7'd51;
        end else if (i_cfg_we) begin
            r_fill_limit <= i_cfg_wdata;
        end
    end

    ohash_front #(.CAPACITY(CAPACITY)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .i_hold      (w_bstat.clearing),
        .o_full      (full),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd_item  (w_cmd_item),
        .o_cmd_home  (w_cmd_home),
        .i_cmd_pop   (w_cmd_pop)
    );

    ohash_back #(.CAPACITY(CAPACITY)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fill_limit (r_fill_limit),
        .i_cmd_valid  (w_cmd_valid),
        .i_cmd_item   (w_cmd_item),
        .i_cmd_home   (w_cmd_home),
        .o_cmd_pop    (w_cmd_pop),
        .o_status     (w_bstat),
        .o_result     (o_result),
        .o_empty      (empty),
        .i_pop        (pop)
    );

    a_pop_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_pop |-> w_cmd_valid && w_bstat.idle)
        else $error("request taken outside idle engine");

    a_full_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_bstat.clearing |-> full)
        else $error("input open during clearing pass");

    a_clear_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_bstat.clearing |=> !w_bstat.clearing)
        else $error("clearing pass restarted");

endmodule

// ----- bench/tb_open_addressing_hash_table_top.sv -----
// Testbench for open_addressing_hash_table_top: directed and random inserts,
// removes and lookups against a behavioral table, with random push/pop idling.
// Depends on ohash_pkg and the block's RTL.
class hash_scoreboard;
    localparam int CAP = 64;
    logic [1:0]  row_state [CAP];
    logic [31:0] row_key   [CAP];
    logic [31:0] row_value [CAP];
    int unsigned filled;
    int unsigned limit;
    ohash_pkg::t_out pending[$];
    int errors;
    int n_checked;
    int status_seen[4];

    function void clear_table();
        for (int i = 0; i < CAP; i++) begin
            row_state[i] = ohash_pkg::SLOT_NEVER;
            row_key[i] = 32'hFFFF_FFFF;
            row_value[i] = 32'd0;
        end
        filled = 0;
        limit = 51;
        errors = 0;
        n_checked = 0;
    endfunction

    function int home_of(logic [31:0] k);
        logic [31:0] t;
        t = k * 32'd3;
        return int'(t[5:0]);
    endfunction

    function int step_of(int p);
        return (6 * p + 1) % CAP;
    endfunction

    function bit hit(int p, logic [31:0] k);
        return row_state[p] == ohash_pkg::SLOT_FILLED && row_key[p] == k;
    endfunction

    // Work out the result of one accepted request and queue it.
    function void note_request(ohash_pkg::t_in it);
        ohash_pkg::t_out r;
        int p;
        int moves;
        bit done;
        logic [31:0] k;
        k = it.key;
        p = home_of(k);
        r.status = ohash_pkg::STAT_OK;
        r.found_value = '0;
        done = 0;
        if (it.mode == ohash_pkg::MODE_INSERT) begin
            if (filled >= limit) begin
                r.status = ohash_pkg::STAT_FULL;
            end else if (hit(p, k)) begin
                row_value[p] = it.value;
            end else begin
                r.status = ohash_pkg::STAT_PROBE_LIM;
                for (int i = 0; i < CAP && !done; i++) begin
                    if (row_state[p] != ohash_pkg::SLOT_FILLED) begin
                        row_state[p] = ohash_pkg::SLOT_FILLED;
                        row_key[p] = k;
                        row_value[p] = it.value;
                        filled++;
                        r.status = ohash_pkg::STAT_OK;
                        done = 1;
                    end else begin
                        p = step_of(p);
                    end
                end
            end
        end else if (it.mode == ohash_pkg::MODE_REMOVE) begin
            moves = 0;
            while (!done && !hit(p, k)) begin
                if (row_state[p] == ohash_pkg::SLOT_NEVER) begin
                    r.status = ohash_pkg::STAT_NOT_FOUND;
                    done = 1;
                end else begin
                    p = step_of(p);
                    moves++;
                    if (moves >= filled) begin
                        r.status = ohash_pkg::STAT_PROBE_LIM;
                        done = 1;
                    end
                end
            end
            if (!done) begin
                row_state[p] = ohash_pkg::SLOT_REMOVED;
                row_key[p] = 32'hFFFF_FFFF;
                row_value[p] = 32'd0;
                filled--;
            end
        end else if (it.mode == ohash_pkg::MODE_LOOKUP) begin
            moves = 0;
            while (!done && !hit(p, k)) begin
                if (row_state[p] == ohash_pkg::SLOT_NEVER) begin
                    r.status = ohash_pkg::STAT_NOT_FOUND;
                    done = 1;
                end else begin
                    moves++;
                    if (moves >= filled) begin
                        r.status = ohash_pkg::STAT_PROBE_LIM;
                        done = 1;
                    end else begin
                        p = step_of(p);
                    end
                end
            end
            if (!done) r.found_value = row_value[p];
        end
        r.entry_count = filled[6:0];
        pending.push_back(r);
    endfunction

    function void check_result(ohash_pkg::t_out got);
        ohash_pkg::t_out want;
        if (pending.size() == 0) begin
            $display("%0t: result with none expected: %h", $time, got);
            errors++;
            return;
        end
        want = pending.pop_front();
        n_checked++;
        status_seen[want.status]++;
        if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            errors++;
        end
        if (got.found_value !== want.found_value) begin
            $display("%0t: found_value expected %h actual %h", $time,
                     want.found_value, got.found_value);
            errors++;
        end
        if (got.entry_count !== want.entry_count) begin
            $display("%0t: entry_count expected %0d actual %0d", $time,
                     want.entry_count, got.entry_count);
            errors++;
        end
    endfunction
endclass

module tb_open_addressing_hash_table_top;
    // mode code that the block leaves unused
    localparam logic [1:0] MODE_SPARE = 2'd3;

    logic i_clk;
    logic i_rst_n;
    logic push;
    logic full;
    ohash_pkg::t_in i_item;
    logic empty;
    logic pop;
    ohash_pkg::t_out o_result;
    logic i_cfg_we;
    logic [ohash_pkg::COUNT_BITS-1:0] i_cfg_wdata;

    hash_scoreboard table_model;
    int push_idle_pct;
    int pop_idle_pct;
    int n_pushed;
    logic [31:0] key_pool[16];

    open_addressing_hash_table_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full), .i_item(i_item),
        .empty(empty), .pop(pop), .o_result(o_result),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop; the slowest correct run stays well below this.
    initial begin
        #4000000;
        $display("tb_open_addressing_hash_table_top: FAIL");
        $finish;
    end

    // Result side: pop at random, check every accepted result.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) table_model.check_result(o_result);
            pop <= ($urandom_range(99) >= pop_idle_pct);
        end
    end

    // Present one item and hold it until accepted; idle at random first.
    // Push stays high after acceptance; the next call or the caller drops it.
    task automatic send_item(logic [1:0] m, logic [31:0] k, logic [31:0] v);
        while ($urandom_range(99) < push_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_item <= '{mode: m, key: k, value: v};
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        table_model.note_request('{mode: m, key: k, value: v});
        n_pushed++;
    endtask

    // Drain all results, settle, then write the fill limit.
    task automatic set_limit(int lim);
        push <= 1'b0;
        @(posedge i_clk);
        while (table_model.pending.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= lim[6:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        table_model.limit = lim;
    endtask

    // Mostly keys from a small pool so removes and lookups hit; some raw noise.
    function automatic logic [31:0] pick_key();
        if ($urandom_range(99) < 80) return key_pool[$urandom_range(15)];
        return $urandom;
    endfunction

    task automatic random_phase(int n, int hi_mode);
        logic [1:0] m;
        for (int i = 0; i < n; i++) begin
            m = 2'($urandom_range(hi_mode));
            send_item(m, pick_key(), $urandom);
        end
    endtask

    initial begin
        int wait_cycles;
        table_model = new();
        table_model.clear_table();
        push = 0;
        i_item = '0;
        i_cfg_we = 0;
        i_cfg_wdata = '0;
        i_rst_n = 0;
        push_idle_pct = 34;
        pop_idle_pct = 34;
        n_pushed = 0;
        for (int i = 0; i < 16; i++) key_pool[i] = $urandom;
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'hFFFF_FFFF;
        key_pool[3] = 32'h0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: key extremes, every mode, misses on empty table and on key -1.
        send_item(ohash_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, 32'h0);
        send_item(ohash_pkg::MODE_REMOVE, 32'hFFFF_FFFF, 32'h0);
        send_item(ohash_pkg::MODE_INSERT, 32'h8000_0000, 32'hFFFF_FFFF);
        send_item(ohash_pkg::MODE_INSERT, 32'h7FFF_FFFF, 32'h0);
        send_item(ohash_pkg::MODE_INSERT, 32'h8000_0000, 32'h1234_5678);
        send_item(ohash_pkg::MODE_LOOKUP, 32'h8000_0000, 32'h0);
        send_item(ohash_pkg::MODE_INSERT, 32'h0, 32'hAAAA_5555);
        send_item(ohash_pkg::MODE_INSERT, 32'h40, 32'h5555_AAAA);
        send_item(ohash_pkg::MODE_LOOKUP, 32'h40, 32'h0);
        send_item(ohash_pkg::MODE_REMOVE, 32'h0, 32'h0);
        send_item(ohash_pkg::MODE_LOOKUP, 32'h40, 32'h0);
        send_item(ohash_pkg::MODE_INSERT, 32'h40, 32'h0BAD_CAFE);
        send_item(MODE_SPARE, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_item(ohash_pkg::MODE_REMOVE, 32'h1234_0000, 32'h0);
        send_item(ohash_pkg::MODE_LOOKUP, 32'h7FFF_FFFF, 32'h0);

        // Limit zero: every insert refused.
        set_limit(0);
        random_phase(40, 3);
        // Full capacity: drive the table toward probe-limit on inserts.
        set_limit(64);
        for (int i = 0; i < 90; i++) send_item(ohash_pkg::MODE_INSERT, $urandom, $urandom);
        random_phase(60, 2);
        set_limit(5);
        random_phase(250, 3);
        // Stretch with no idling at all.
        push_idle_pct = 0;
        pop_idle_pct = 0;
        set_limit(51);
        random_phase(300, 2);
        push_idle_pct = 34;
        pop_idle_pct = 34;
        set_limit(20);
        random_phase(300, 3);
        set_limit(127);
        random_phase(300, 2);

        push <= 1'b0;
        wait_cycles = 0;
        while (table_model.pending.size() != 0 && wait_cycles < 100000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (300) @(posedge i_clk);
        $display("Sent %0d requests, checked %0d results", n_pushed, table_model.n_checked);
        $display("(ok %0d, miss %0d, probe limit %0d, full %0d).",
                 table_model.status_seen[0], table_model.status_seen[1],
                 table_model.status_seen[2], table_model.status_seen[3]);
        if (table_model.pending.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, table_model.pending.size());
            table_model.errors++;
        end
        if (table_model.errors == 0) begin
            $display("tb_open_addressing_hash_table_top: PASS");
        end else begin
            $display("tb_open_addressing_hash_table_top: FAIL");
        end
        $finish;
    end
endmodule

// ----- files.f -----
design/ohash_pkg.sv
design/ohash_ram.sv
design/ohash_fifo.sv
design/ohash_front.sv
design/ohash_back.sv
design/open_addressing_hash_table_top.sv
bench/tb_open_addressing_hash_table_top.sv
